// File: sv/assert_macros.svh
// Assertion macros used by the shard assigner datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ASSERT_ON(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_ON(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

// File: sv/llsa_pkg.sv
// Types, codes and microcode table of the least-loaded shard assigner.
`default_nettype none
package llsa_pkg;

   localparam int ID_W         = 32;
   localparam int PORT_W       = 16;
   localparam int STATUS_W     = 3;
   localparam int SHARD_OUT_W  = 4;
   localparam int MEMBERS_W    = 7;
   localparam int SHARD_TOTAL_W = 5;
   localparam int STEP_W       = 4;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NO_SHARDS = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

   // Register index of shard_total
   localparam logic CSR_SHARD_TOTAL = 1'b0;

   // Microprogram step addresses
   localparam logic [STEP_W-1:0] STEP_IDLE    = 4'd0;
   localparam logic [STEP_W-1:0] STEP_CHECK   = 4'd1;
   localparam logic [STEP_W-1:0] STEP_ID_SCAN = 4'd2;
   localparam logic [STEP_W-1:0] STEP_DUP_CHK = 4'd3;
   localparam logic [STEP_W-1:0] STEP_SH_CHK  = 4'd4;
   localparam logic [STEP_W-1:0] STEP_FULL    = 4'd5;
   localparam logic [STEP_W-1:0] STEP_SH_SCAN = 4'd6;
   localparam logic [STEP_W-1:0] STEP_PRIM_RD = 4'd7;
   localparam logic [STEP_W-1:0] STEP_UPDATE  = 4'd8;
   localparam logic [STEP_W-1:0] STEP_RESP    = 4'd9;

   typedef enum logic [3:0] {
      COND_NEVER,
      COND_NO_REQ,
      COND_BAD,
      COND_ID_LOOP,
      COND_HIT,
      COND_NO_SHARDS,
      COND_FULL,
      COND_SH_LOOP,
      COND_OUT_BUSY
   } cond_type;

   typedef struct packed {
      logic [ID_W-1:0]   replica_id;
      logic              addr_present;
      logic [PORT_W-1:0] port_number;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]    status;
      logic [SHARD_OUT_W-1:0] assigned_shard;
      logic                   became_primary;
      logic [ID_W-1:0]        shard_primary;
      logic [MEMBERS_W-1:0]   shard_members;
   } rsp_type;

   // One control word per step
   typedef struct packed {
      logic                take;
      logic                init;
      logic                id_scan;
      logic                sh_init;
      logic                sh_scan;
      logic                prim_rd;
      logic                update;
      logic                load_rsp;
      logic                set_status;
      logic [STATUS_W-1:0] status;
      cond_type            cond;
      logic [STEP_W-1:0]   jump_step;
      logic [STEP_W-1:0]   next_step;
   } cw_type;

   // Status flags from the datapath to the sequencer
   typedef struct packed {
      logic no_req;
      logic bad;
      logic id_loop;
      logic hit;
      logic no_shards;
      logic full;
      logic sh_loop;
      logic out_busy;
   } flags_type;

   // Microprogram
   function automatic cw_type seq_rom(input logic [STEP_W-1:0] step);
      cw_type w;
      w = '0;
      w.cond = COND_NEVER;
      w.jump_step = STEP_RESP;
      case (step)
         STEP_IDLE: begin
            w.take = 1'b1;
            w.cond = COND_NO_REQ;
            w.jump_step = STEP_IDLE;
            w.next_step = STEP_CHECK;
         end
         STEP_CHECK: begin
            w.init = 1'b1;
            w.set_status = 1'b1;
            w.status = ST_INVALID;
            w.cond = COND_BAD;
            w.next_step = STEP_ID_SCAN;
         end
         STEP_ID_SCAN: begin
            w.id_scan = 1'b1;
            w.cond = COND_ID_LOOP;
            w.jump_step = STEP_ID_SCAN;
            w.next_step = STEP_DUP_CHK;
         end
         STEP_DUP_CHK: begin
            w.set_status = 1'b1;
            w.status = ST_DUPLICATE;
            w.cond = COND_HIT;
            w.next_step = STEP_SH_CHK;
         end
         STEP_SH_CHK: begin
            w.set_status = 1'b1;
            w.status = ST_NO_SHARDS;
            w.cond = COND_NO_SHARDS;
            w.next_step = STEP_FULL;
         end
         STEP_FULL: begin
            w.sh_init = 1'b1;
            w.set_status = 1'b1;
            w.status = ST_FULL;
            w.cond = COND_FULL;
            w.next_step = STEP_SH_SCAN;
         end
         STEP_SH_SCAN: begin
            w.sh_scan = 1'b1;
            w.cond = COND_SH_LOOP;
            w.jump_step = STEP_SH_SCAN;
            w.next_step = STEP_PRIM_RD;
         end
         STEP_PRIM_RD: begin
            w.prim_rd = 1'b1;
            w.next_step = STEP_UPDATE;
         end
         STEP_UPDATE: begin
            w.update = 1'b1;
            w.next_step = STEP_RESP;
         end
         STEP_RESP: begin
            w.load_rsp = 1'b1;
            w.cond = COND_OUT_BUSY;
            w.jump_step = STEP_RESP;
            w.next_step = STEP_IDLE;
         end
         default: begin
            w.next_step = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

// File: sv/llsa_seq.sv
// Microcode sequencer: step counter, control store and branch logic.
`default_nettype none
module llsa_seq (
   input  wire                      clock,
   input  wire                      reset,
   input  wire llsa_pkg::flags_type flags,
   output llsa_pkg::cw_type         cw,
   output logic                     jump
);

   logic [llsa_pkg::STEP_W-1:0] step_ff;
   logic [llsa_pkg::STEP_W-1:0] step_in;

   // Fetch the control word of the current step
   assign cw = llsa_pkg::seq_rom(step_ff);

   // Evaluate the branch condition
   always_comb begin
      case (cw.cond)
         llsa_pkg::COND_NEVER:     jump = 1'b0;
         llsa_pkg::COND_NO_REQ:    jump = flags.no_req;
         llsa_pkg::COND_BAD:       jump = flags.bad;
         llsa_pkg::COND_ID_LOOP:   jump = flags.id_loop;
         llsa_pkg::COND_HIT:       jump = flags.hit;
         llsa_pkg::COND_NO_SHARDS: jump = flags.no_shards;
         llsa_pkg::COND_FULL:      jump = flags.full;
         llsa_pkg::COND_SH_LOOP:   jump = flags.sh_loop;
         llsa_pkg::COND_OUT_BUSY:  jump = flags.out_busy;
         default:                  jump = 1'b0;
      endcase
      step_in = jump ? cw.jump_step : cw.next_step;
   end

   // Advance the step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= llsa_pkg::STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule
`default_nettype wire

// File: sv/llsa_dpath.sv
// Datapath: id table, shard count and primary stores, scan units, result register.
`default_nettype none
`include "assert_macros.svh"
module llsa_dpath #(
   parameter int MAX_MEMBERS = 64,
   parameter int MAX_SHARDS  = 16
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire llsa_pkg::cw_type                  cw,
   input  wire                                    jump,
   output llsa_pkg::flags_type                    flags,
   input  wire                                    req_valid,
   input  wire llsa_pkg::req_type                 req,
   output logic                                   rsp_valid,
   input  wire                                    rsp_stall,
   output llsa_pkg::rsp_type                      rsp,
   input  wire [llsa_pkg::SHARD_TOTAL_W-1:0]      shard_total,
   input  wire                                    cfg_clr
);

   localparam int AW   = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
   localparam int CNW  = $clog2(MAX_MEMBERS + 1);
   localparam int SW   = (MAX_SHARDS > 1) ? $clog2(MAX_SHARDS) : 1;
   localparam int SXW  = $clog2(MAX_SHARDS + 1);
   localparam int CMPW = (SXW > llsa_pkg::SHARD_TOTAL_W) ? SXW : llsa_pkg::SHARD_TOTAL_W;

   // Stores
   logic [llsa_pkg::ID_W-1:0] id_mem_ff   [MAX_MEMBERS];
   logic [CNW-1:0]            cnt_mem_ff  [MAX_SHARDS];
   logic [llsa_pkg::ID_W-1:0] prim_mem_ff [MAX_SHARDS];

   // Store read data
   logic [llsa_pkg::ID_W-1:0] id_rd_ff;
   logic [CNW-1:0]            cnt_rd_ff;
   logic                      vld_rd_ff;
   logic [llsa_pkg::ID_W-1:0] prim_rd_ff;
   logic                      tvld_ff;

   llsa_pkg::req_type             req_ff, req_in;
   logic [llsa_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [SW-1:0]                 target_ff, target_in;
   logic                          became_ff, became_in;
   logic [llsa_pkg::ID_W-1:0]     prim_ff, prim_in;
   logic [CNW-1:0]                members_ff, members_in;
   logic [CNW-1:0]                total_ff, total_in;
   logic [CNW-1:0]                idx_ff, idx_in;
   logic                          id_pend_ff, id_pend_in;
   logic                          hit_ff, hit_in;
   logic [SXW-1:0]                sidx_ff, sidx_in;
   logic                          sh_pend_ff, sh_pend_in;
   logic [SW-1:0]                 sh_pidx_ff, sh_pidx_in;
   logic [CNW-1:0]                best_ff, best_in;
   logic [MAX_SHARDS-1:0]         shard_vld_ff, shard_vld_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   llsa_pkg::rsp_type             rsp_ff, rsp_in;

   logic           id_more;
   logic           sh_more;
   logic [CNW-1:0] cnt_now;
   logic           rsp_load;

   assign id_more = idx_ff < total_ff;
   assign sh_more = CMPW'(sidx_ff) < CMPW'(shard_total);
   assign cnt_now = vld_rd_ff ? cnt_rd_ff : '0;
   assign rsp_load = cw.load_rsp && !(rsp_valid_ff && rsp_stall);

   // Flags for the sequencer
   always_comb begin
      flags.no_req    = !req_valid;
      flags.bad       = (req_ff.replica_id == '0) || !req_ff.addr_present ||
                        (req_ff.port_number == '0);
      flags.id_loop   = (id_more || id_pend_ff) && !hit_ff;
      flags.hit       = hit_ff;
      flags.no_shards = (shard_total == '0);
      flags.full      = (total_ff >= CNW'(MAX_MEMBERS));
      flags.sh_loop   = sh_more || sh_pend_ff;
      flags.out_busy  = rsp_valid_ff && rsp_stall;
   end

   // Next-state logic driven by the control word
   always_comb begin
      req_in       = req_ff;
      status_in    = status_ff;
      target_in    = target_ff;
      became_in    = became_ff;
      prim_in      = prim_ff;
      members_in   = members_ff;
      total_in     = total_ff;
      idx_in       = idx_ff;
      id_pend_in   = id_pend_ff;
      hit_in       = hit_ff;
      sidx_in      = sidx_ff;
      sh_pend_in   = sh_pend_ff;
      sh_pidx_in   = sh_pidx_ff;
      best_in      = best_ff;
      shard_vld_in = shard_vld_ff;
      rsp_in       = rsp_ff;

      // Latch the offered item
      if (cw.take && req_valid) begin
         req_in = req;
      end

      // Start a new item with empty results
      if (cw.init) begin
         status_in  = llsa_pkg::ST_ADDED;
         target_in  = '0;
         became_in  = 1'b0;
         prim_in    = '0;
         members_in = '0;
         idx_in     = '0;
         id_pend_in = 1'b0;
         hit_in     = 1'b0;
      end

      // Record a rejection on a taken branch
      if (cw.set_status && jump) begin
         status_in = cw.status;
      end

      // Duplicate search: issue one read, compare the previous one
      if (cw.id_scan) begin
         id_pend_in = id_more;
         if (id_more) begin
            idx_in = idx_ff + 1'b1;
         end
         if (id_pend_ff && (id_rd_ff == req_ff.replica_id)) begin
            hit_in = 1'b1;
         end
      end

      // Least-loaded search setup
      if (cw.sh_init) begin
         sidx_in    = '0;
         sh_pend_in = 1'b0;
         best_in    = '1;
         target_in  = '0;
      end

      // Least-loaded search: strict compare keeps the lowest index on ties
      if (cw.sh_scan) begin
         sh_pend_in = sh_more;
         sh_pidx_in = sidx_ff[SW-1:0];
         if (sh_more) begin
            sidx_in = sidx_ff + 1'b1;
         end
         if (sh_pend_ff && (cnt_now < best_ff)) begin
            best_in   = cnt_now;
            target_in = sh_pidx_ff;
         end
      end

      // Commit the new member
      if (cw.update) begin
         total_in   = total_ff + 1'b1;
         members_in = best_ff + 1'b1;
         became_in  = !tvld_ff;
         prim_in    = tvld_ff ? prim_rd_ff : req_ff.replica_id;
         shard_vld_in[target_ff] = 1'b1;
      end

      // Drop all shard state on a shard_total write
      if (cfg_clr) begin
         shard_vld_in = '0;
      end

      // Result register
      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
      if (rsp_load) begin
         rsp_in.status         = status_ff;
         rsp_in.assigned_shard = llsa_pkg::SHARD_OUT_W'(target_ff);
         rsp_in.became_primary = became_ff;
         rsp_in.shard_primary  = prim_ff;
         rsp_in.shard_members  = llsa_pkg::MEMBERS_W'(members_ff);
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         id_pend_ff   <= 1'b0;
         hit_ff       <= 1'b0;
         sh_pend_ff   <= 1'b0;
         shard_vld_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         total_ff     <= total_in;
         id_pend_ff   <= id_pend_in;
         hit_ff       <= hit_in;
         sh_pend_ff   <= sh_pend_in;
         shard_vld_ff <= shard_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      status_ff  <= status_in;
      target_ff  <= target_in;
      became_ff  <= became_in;
      prim_ff    <= prim_in;
      members_ff <= members_in;
      idx_ff     <= idx_in;
      sidx_ff    <= sidx_in;
      sh_pidx_ff <= sh_pidx_in;
      best_ff    <= best_in;
      rsp_ff     <= rsp_in;
   end

   // Id table
   always_ff @(posedge clock) begin
      if (cw.id_scan && id_more) begin
         id_rd_ff <= id_mem_ff[idx_ff[AW-1:0]];
      end
      if (cw.update) begin
         id_mem_ff[total_ff[AW-1:0]] <= req_ff.replica_id;
      end
   end

   // Shard counts; an entry without its valid bit reads as zero
   always_ff @(posedge clock) begin
      if (cw.sh_scan && sh_more) begin
         cnt_rd_ff <= cnt_mem_ff[sidx_ff[SW-1:0]];
         vld_rd_ff <= shard_vld_ff[sidx_ff[SW-1:0]];
      end
      if (cw.update) begin
         cnt_mem_ff[target_ff] <= best_ff + 1'b1;
      end
   end

   // Shard primaries
   always_ff @(posedge clock) begin
      if (cw.prim_rd) begin
         prim_rd_ff <= prim_mem_ff[target_ff];
         tvld_ff    <= shard_vld_ff[target_ff];
      end
      if (cw.update && !tvld_ff) begin
         prim_mem_ff[target_ff] <= req_ff.replica_id;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   `ASSERT_ON(a_total_bound, clock, reset, total_ff <= CNW'(MAX_MEMBERS))
   `ASSERT_ON(a_update_legal, clock, reset, cw.update |-> (!hit_ff && !flags.full && !flags.bad && !flags.no_shards))
   `ASSERT_NEVER(a_target_range, clock, reset, cw.update && (CMPW'(target_ff) >= CMPW'(shard_total)))
   `ASSERT_ON(a_added_counted, clock, reset, (rsp_load && (status_ff == llsa_pkg::ST_ADDED)) |-> (members_ff != '0))

endmodule
`default_nettype wire

// File: sv/least_loaded_shard_assigner_top.sv
// Top level of the least-loaded shard assigner: register port, sequencer and datapath.
`default_nettype none
// Takes one member at a time. An added member first passes the duplicate check, which
// reads the stored ids one entry per cycle through the id table's single read port;
// then the shard counts are read one per cycle to find the least-loaded shard, lowest
// index on ties. A rejected member ends sooner. The result sits in an output register,
// so the next item is taken while a finished result waits; a result still stalled when
// the next one is ready holds the sequencer at its last step. Writing shard_total
// empties all shards at once; stored ids are kept. Only the low five bits of the write
// are used, and a value above MAX_SHARDS saturates to MAX_SHARDS, or to 31 if that is
// smaller. There is no clearing pass after reset.
module least_loaded_shard_assigner_top #(
   parameter int MAX_MEMBERS = 64,
   parameter int MAX_SHARDS  = 16
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  wire llsa_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output llsa_pkg::rsp_type      rsp_data,
   input  wire                    csr_psel,
   input  wire                    csr_penable,
   input  wire                    csr_pwrite,
   input  wire [2:0]              csr_paddr,
   input  wire [31:0]             csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);

   localparam int SAT_LIM = (MAX_SHARDS > 31) ? 31 : MAX_SHARDS;

   llsa_pkg::cw_type    cw;
   llsa_pkg::flags_type flags;
   logic                jump;

   logic [llsa_pkg::SHARD_TOTAL_W-1:0] shard_total_ff, shard_total_in;
   logic [llsa_pkg::SHARD_TOTAL_W-1:0] wr_val;
   logic                               cfg_wr;
   logic                               cfg_clr;

   // Register port
   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg_clr    = cfg_wr && (csr_paddr[2] == llsa_pkg::CSR_SHARD_TOTAL);
   assign wr_val     = csr_pwdata[llsa_pkg::SHARD_TOTAL_W-1:0];

   // Saturate shard_total to the number of shards built, at most 31
   always_comb begin
      shard_total_in = shard_total_ff;
      if (cfg_clr) begin
         if (wr_val > llsa_pkg::SHARD_TOTAL_W'(SAT_LIM)) begin
            shard_total_in = llsa_pkg::SHARD_TOTAL_W'(SAT_LIM);
         end else begin
            shard_total_in = wr_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shard_total_ff <= '0;
      end else begin
         shard_total_ff <= shard_total_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == llsa_pkg::CSR_SHARD_TOTAL) ?
                       32'(shard_total_ff) : '0;

   // Items are taken only at the idle step
   assign req_stall = !cw.take;

   llsa_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .cw    (cw),
      .jump  (jump)
   );

   llsa_dpath #(
      .MAX_MEMBERS (MAX_MEMBERS),
      .MAX_SHARDS  (MAX_SHARDS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cw          (cw),
      .jump        (jump),
      .flags       (flags),
      .req_valid   (req_valid),
      .req         (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp         (rsp_data),
      .shard_total (shard_total_ff),
      .cfg_clr     (cfg_clr)
   );

endmodule
`default_nettype wire
